>>> hdl/image_block_downscaler_assert.svh
// Assertion macros shared by the downscaler modules.
// Each macro expects i_clk and i_rst_n in the scope where it is used.
`ifndef IMAGE_BLOCK_DOWNSCALER_ASSERT_SVH
`define IMAGE_BLOCK_DOWNSCALER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define IBD_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define IBD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/ibd_pkg.sv
package ibd_pkg;

    localparam int unsigned FACTOR_W = 5;
    localparam int unsigned SIZE_REG_W = 13;
    localparam int unsigned SUM_W = 16;
    localparam int unsigned ENTRY_W = 3 * SUM_W;

    // Reciprocal of the block divisor, scaled by 2**RECIP_K and rounded up.
    // For any 16-bit sum and a divisor below 1024 the top bits of the
    // product give the exact truncated quotient.
    localparam int unsigned RECIP_K = 26;
    localparam int unsigned RECIP_W = RECIP_K + 1;
    localparam int unsigned RECIP_ONE = 2 ** RECIP_K;
    localparam int unsigned PROD_W = SUM_W + RECIP_W;

    // Indexed by the clamped factor; the Gaussian factor divides by 16.
    localparam logic [RECIP_W-1:0] RECIP [32] = '{
        RECIP_W'(RECIP_ONE),
        RECIP_W'(RECIP_ONE),
        RECIP_W'((RECIP_ONE + 3) / 4),
        RECIP_W'((RECIP_ONE + 15) / 16),
        RECIP_W'((RECIP_ONE + 15) / 16),
        RECIP_W'((RECIP_ONE + 24) / 25),
        RECIP_W'((RECIP_ONE + 35) / 36),
        RECIP_W'((RECIP_ONE + 48) / 49),
        RECIP_W'((RECIP_ONE + 63) / 64),
        RECIP_W'((RECIP_ONE + 80) / 81),
        RECIP_W'((RECIP_ONE + 99) / 100),
        RECIP_W'((RECIP_ONE + 120) / 121),
        RECIP_W'((RECIP_ONE + 143) / 144),
        RECIP_W'((RECIP_ONE + 168) / 169),
        RECIP_W'((RECIP_ONE + 195) / 196),
        RECIP_W'((RECIP_ONE + 224) / 225),
        RECIP_W'((RECIP_ONE + 255) / 256),
        RECIP_W'((RECIP_ONE + 288) / 289),
        RECIP_W'((RECIP_ONE + 323) / 324),
        RECIP_W'((RECIP_ONE + 360) / 361),
        RECIP_W'((RECIP_ONE + 399) / 400),
        RECIP_W'((RECIP_ONE + 440) / 441),
        RECIP_W'((RECIP_ONE + 483) / 484),
        RECIP_W'((RECIP_ONE + 528) / 529),
        RECIP_W'((RECIP_ONE + 575) / 576),
        RECIP_W'((RECIP_ONE + 624) / 625),
        RECIP_W'((RECIP_ONE + 675) / 676),
        RECIP_W'((RECIP_ONE + 728) / 729),
        RECIP_W'((RECIP_ONE + 783) / 784),
        RECIP_W'((RECIP_ONE + 840) / 841),
        RECIP_W'((RECIP_ONE + 899) / 900),
        RECIP_W'((RECIP_ONE + 960) / 961)
    };

    // 3x3 Gaussian kernel, row-major.
    localparam logic [2:0] GAUSS_W [9] = '{
        3'd1, 3'd2, 3'd1,
        3'd2, 3'd4, 3'd2,
        3'd1, 3'd2, 3'd1
    };

    localparam int unsigned QDEPTH = 4;
    localparam int unsigned QAW = 2;

    typedef enum logic [1:0] {
        REG_SCALE_FACTOR,
        REG_IN_WIDTH,
        REG_IN_HEIGHT,
        REG_COLOR_MODE
    } t_reg_idx;

    typedef enum logic [1:0] {
        DIV_IDLE,
        DIV_LOAD,
        DIV_RUN,
        DIV_DONE
    } t_div_state;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [2:0] weight;
        logic       first;
        logic       emit;
        logic       eol;
        logic       eoi;
    } t_px_cmd;

    typedef struct packed {
        logic [FACTOR_W-1:0] factor;
        logic                gauss;
        logic                rgb;
        logic                busy;
    } t_cfg_ctl;

    // Remainder modulo 3 of a 5-bit value; powers of two alternate 1, 2 mod 3.
    function automatic logic [1:0] mod3(input logic [4:0] x);
        logic [2:0] s;
        s = 3'(x[0]) + 3'({x[1], 1'b0}) + 3'(x[2]) + 3'({x[3], 1'b0}) + 3'(x[4]);
        if (s >= 3'd6) begin
            mod3 = 2'(s - 3'd6);
        end else if (s >= 3'd3) begin
            mod3 = 2'(s - 3'd3);
        end else begin
            mod3 = s[1:0];
        end
    endfunction

endpackage

>>> hdl/image_block_downscaler.sv
// Box-filter image downscaler.
// Pixels enter on the input channel (i_valid, o_stall, i_red/i_green/i_blue)
// in raster order, one transfer per pixel. Each non-overlapping block of
// factor by factor pixels yields one output transfer (o_valid, i_stall,
// o_out_*, o_end_of_row, o_end_of_image) carrying the truncated block
// average, or the 3x3 Gaussian-weighted sum over 16 when the factor is 3.
// Pixels right of or below the last full block are taken and dropped.
// Throughput is one pixel per clock while o_stall is low. A result is formed
// once the bottom-right pixel of its block has passed the queue, whose head
// address reads its column sum, then the accumulate and write back, and then
// the reciprocal multiply into the output register.
// After reset, and after every register write, a setup divider finds the
// output width and the block limits. It holds o_stall high from reset, or
// from the access cycle of a write, through its load state, DIVN division
// steps and its done state, where DIVN is the bit width of the larger
// maximum dimension (13 with default sizes).
// When the receiver stalls, the result is held in the output register and
// the back end freezes; the four-entry queue then absorbs pixels until it
// fills and o_stall rises.
module image_block_downscaler #(
    parameter int unsigned MAX_WIDTH  = 4096,
    parameter int unsigned MAX_HEIGHT = 4096,
    parameter int unsigned MAX_FACTOR = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Pixel input channel.
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_red,
    input  logic [7:0]  i_green,
    input  logic [7:0]  i_blue,
    // Result output channel.
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_out_red,
    output logic [7:0]  o_out_green,
    output logic [7:0]  o_out_blue,
    output logic        o_end_of_row,
    output logic        o_end_of_image,
    // Register port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int unsigned CW = $clog2(MAX_WIDTH);
    localparam int unsigned W_W = $clog2(MAX_WIDTH + 1);
    localparam int unsigned H_W = $clog2(MAX_HEIGHT + 1);
    localparam int unsigned QW = $bits(ibd_pkg::t_px_cmd) + CW;

    ibd_pkg::t_cfg_ctl cfg_ctl;
    logic [W_W-1:0] cfg_w;
    logic [H_W-1:0] cfg_h;
    logic [W_W-1:0] cfg_out_w;
    logic [W_W-1:0] cfg_lim_w;
    logic [H_W-1:0] cfg_lim_h;
    logic [ibd_pkg::RECIP_W-1:0] cfg_recip;

    logic             q_full;
    logic             q_push;
    ibd_pkg::t_px_cmd push_cmd;
    logic [CW-1:0]    push_addr;
    logic             q_pop;
    logic             q_valid;
    logic [QW-1:0]    q_data;
    ibd_pkg::t_px_cmd head_cmd;
    logic [CW-1:0]    head_addr;

    // Register file and the setup divider for the derived limits.
    ibd_cfg #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .MAX_FACTOR (MAX_FACTOR)
    ) u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_ctl   (cfg_ctl),
        .o_w     (cfg_w),
        .o_h     (cfg_h),
        .o_out_w (cfg_out_w),
        .o_lim_w (cfg_lim_w),
        .o_lim_h (cfg_lim_h),
        .o_recip (cfg_recip)
    );

    // Front end: tracks the raster position and classifies each pixel.
    ibd_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_red   (i_red),
        .i_green (i_green),
        .i_blue  (i_blue),
        .i_ctl   (cfg_ctl),
        .i_w     (cfg_w),
        .i_h     (cfg_h),
        .i_out_w (cfg_out_w),
        .i_lim_w (cfg_lim_w),
        .i_lim_h (cfg_lim_h),
        .i_full  (q_full),
        .o_push  (q_push),
        .o_cmd   (push_cmd),
        .o_addr  (push_addr)
    );

    ibd_fifo #(
        .WIDTH (QW)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  ({push_cmd, push_addr}),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_data)
    );

    assign head_cmd  = ibd_pkg::t_px_cmd'(q_data[QW-1:CW]);
    assign head_addr = q_data[CW-1:0];

    // Back end: column-sum accumulation and the block divide.
    ibd_back #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_head_valid   (q_valid),
        .i_head_cmd     (head_cmd),
        .i_head_addr    (head_addr),
        .o_pop          (q_pop),
        .i_recip        (cfg_recip),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_out_red      (o_out_red),
        .o_out_green    (o_out_green),
        .o_out_blue     (o_out_blue),
        .o_end_of_row   (o_end_of_row),
        .o_end_of_image (o_end_of_image)
    );

endmodule

>>> hdl/ibd_cfg.sv
`include "image_block_downscaler_assert.svh"

module ibd_cfg #(
    parameter int unsigned MAX_WIDTH  = 4096,
    parameter int unsigned MAX_HEIGHT = 4096,
    parameter int unsigned MAX_FACTOR = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic [3:0]                             paddr,
    input  logic [31:0]                            pwdata,
    output logic [31:0]                            prdata,
    output logic                                   pready,
    output ibd_pkg::t_cfg_ctl                      o_ctl,
    output logic [$clog2(MAX_WIDTH+1)-1:0]         o_w,
    output logic [$clog2(MAX_HEIGHT+1)-1:0]        o_h,
    output logic [$clog2(MAX_WIDTH+1)-1:0]         o_out_w,
    output logic [$clog2(MAX_WIDTH+1)-1:0]         o_lim_w,
    output logic [$clog2(MAX_HEIGHT+1)-1:0]        o_lim_h,
    output logic [ibd_pkg::RECIP_W-1:0]            o_recip
);

    localparam int unsigned FW = ibd_pkg::FACTOR_W;
    localparam int unsigned SW = ibd_pkg::SIZE_REG_W;
    localparam int unsigned W_W = $clog2(MAX_WIDTH + 1);
    localparam int unsigned H_W = $clog2(MAX_HEIGHT + 1);
    localparam int unsigned CMPW_W = (W_W > SW) ? W_W : SW;
    localparam int unsigned CMPH_W = (H_W > SW) ? H_W : SW;
    localparam int unsigned DIVN = (W_W > H_W) ? W_W : H_W;
    localparam int unsigned CNT_W = $clog2(DIVN + 1);

    logic [FW-1:0] r_scale;
    logic [SW-1:0] r_in_width;
    logic [SW-1:0] r_in_height;
    logic          r_color;
    logic          wr;

    ibd_pkg::t_div_state r_state;
    ibd_pkg::t_div_state n_state;

    logic [FW-1:0]   f_c;
    logic [W_W-1:0]  w_c;
    logic [H_W-1:0]  h_c;

    logic [FW-1:0]   r_f_c;
    logic [W_W-1:0]  r_w_c;
    logic [H_W-1:0]  r_h_c;
    logic            r_gauss;
    logic [ibd_pkg::RECIP_W-1:0] r_recip;
    logic [DIVN-1:0] r_dvd_w;
    logic [DIVN-1:0] r_dvd_h;
    logic [DIVN-1:0] r_q_w;
    logic [DIVN-1:0] r_q_h;
    logic [FW-1:0]   r_rem_w;
    logic [FW-1:0]   r_rem_h;
    logic [CNT_W-1:0] r_cnt;
    logic [W_W-1:0]  r_out_w;
    logic [W_W-1:0]  r_lim_w;
    logic [H_W-1:0]  r_lim_h;

    logic [FW:0]     t_w;
    logic [FW:0]     t_h;
    logic            ge_w;
    logic            ge_h;
    logic [FW-1:0]   n_rem_w;
    logic [FW-1:0]   n_rem_h;

    assign wr = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale     <= FW'(2);
            r_in_width  <= SW'(4096);
            r_in_height <= SW'(4096);
            r_color     <= 1'b1;
        end else if (wr) begin
            case (ibd_pkg::t_reg_idx'(paddr[3:2]))
                ibd_pkg::REG_SCALE_FACTOR: r_scale     <= pwdata[FW-1:0];
                ibd_pkg::REG_IN_WIDTH:     r_in_width  <= pwdata[SW-1:0];
                ibd_pkg::REG_IN_HEIGHT:    r_in_height <= pwdata[SW-1:0];
                ibd_pkg::REG_COLOR_MODE:   r_color     <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (ibd_pkg::t_reg_idx'(paddr[3:2]))
            ibd_pkg::REG_SCALE_FACTOR: prdata = 32'(r_scale);
            ibd_pkg::REG_IN_WIDTH:     prdata = 32'(r_in_width);
            ibd_pkg::REG_IN_HEIGHT:    prdata = 32'(r_in_height);
            ibd_pkg::REG_COLOR_MODE:   prdata = 32'(r_color);
            default:                   prdata = '0;
        endcase
    end

    // Out-of-range settings are clamped into the supported range.
    always_comb begin
        if (r_scale == '0) begin
            f_c = FW'(1);
        end else if (7'(r_scale) > 7'(MAX_FACTOR)) begin
            f_c = FW'(MAX_FACTOR);
        end else begin
            f_c = r_scale;
        end
        if (r_in_width == '0) begin
            w_c = W_W'(1);
        end else if (CMPW_W'(r_in_width) > CMPW_W'(MAX_WIDTH)) begin
            w_c = W_W'(MAX_WIDTH);
        end else begin
            w_c = W_W'(r_in_width);
        end
        if (r_in_height == '0) begin
            h_c = H_W'(1);
        end else if (CMPH_W'(r_in_height) > CMPH_W'(MAX_HEIGHT)) begin
            h_c = H_W'(MAX_HEIGHT);
        end else begin
            h_c = H_W'(r_in_height);
        end
    end

    // One restoring division step for width and for height.
    always_comb begin
        t_w = {r_rem_w, r_dvd_w[DIVN-1]};
        t_h = {r_rem_h, r_dvd_h[DIVN-1]};
        ge_w = t_w >= {1'b0, r_f_c};
        ge_h = t_h >= {1'b0, r_f_c};
        n_rem_w = ge_w ? FW'(t_w - {1'b0, r_f_c}) : t_w[FW-1:0];
        n_rem_h = ge_h ? FW'(t_h - {1'b0, r_f_c}) : t_h[FW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ibd_pkg::DIV_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ibd_pkg::DIV_IDLE: n_state = ibd_pkg::DIV_IDLE;
            ibd_pkg::DIV_LOAD: n_state = ibd_pkg::DIV_RUN;
            ibd_pkg::DIV_RUN: begin
                if (r_cnt == CNT_W'(DIVN - 1)) begin
                    n_state = ibd_pkg::DIV_DONE;
                end
            end
            ibd_pkg::DIV_DONE: n_state = ibd_pkg::DIV_IDLE;
            default:           n_state = ibd_pkg::DIV_IDLE;
        endcase
        if (wr) begin
            n_state = ibd_pkg::DIV_LOAD;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            ibd_pkg::DIV_LOAD: begin
                r_f_c   <= f_c;
                r_w_c   <= w_c;
                r_h_c   <= h_c;
                r_gauss <= (f_c == FW'(3));
                r_recip <= ibd_pkg::RECIP[f_c];
                r_dvd_w <= DIVN'(w_c);
                r_dvd_h <= DIVN'(h_c);
                r_q_w   <= '0;
                r_q_h   <= '0;
                r_rem_w <= '0;
                r_rem_h <= '0;
                r_cnt   <= '0;
            end
            ibd_pkg::DIV_RUN: begin
                r_dvd_w <= {r_dvd_w[DIVN-2:0], 1'b0};
                r_dvd_h <= {r_dvd_h[DIVN-2:0], 1'b0};
                r_q_w   <= {r_q_w[DIVN-2:0], ge_w};
                r_q_h   <= {r_q_h[DIVN-2:0], ge_h};
                r_rem_w <= n_rem_w;
                r_rem_h <= n_rem_h;
                r_cnt   <= r_cnt + CNT_W'(1);
            end
            ibd_pkg::DIV_DONE: begin
                // Largest multiple of the factor that fits is size minus remainder.
                r_out_w <= r_q_w[W_W-1:0];
                r_lim_w <= r_w_c - W_W'(r_rem_w);
                r_lim_h <= r_h_c - H_W'(r_rem_h);
            end
            default: ;
        endcase
    end

    always_comb begin
        o_ctl.factor = r_f_c;
        o_ctl.gauss  = r_gauss;
        o_ctl.rgb    = r_color;
        o_ctl.busy   = (r_state != ibd_pkg::DIV_IDLE) || wr;
    end

    assign o_w     = r_w_c;
    assign o_h     = r_h_c;
    assign o_out_w = r_out_w;
    assign o_lim_w = r_lim_w;
    assign o_lim_h = r_lim_h;
    assign o_recip = r_recip;

    `IBD_ASSERT_SAME(a_rem_below_factor, r_state == ibd_pkg::DIV_RUN, (r_rem_w < r_f_c) && (r_rem_h < r_f_c), "divider remainder not below factor")

endmodule

>>> hdl/ibd_front.sv
`include "image_block_downscaler_assert.svh"

module ibd_front #(
    parameter int unsigned MAX_WIDTH  = 4096,
    parameter int unsigned MAX_HEIGHT = 4096
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic [7:0]                          i_red,
    input  logic [7:0]                          i_green,
    input  logic [7:0]                          i_blue,
    input  ibd_pkg::t_cfg_ctl                   i_ctl,
    input  logic [$clog2(MAX_WIDTH+1)-1:0]      i_w,
    input  logic [$clog2(MAX_HEIGHT+1)-1:0]     i_h,
    input  logic [$clog2(MAX_WIDTH+1)-1:0]      i_out_w,
    input  logic [$clog2(MAX_WIDTH+1)-1:0]      i_lim_w,
    input  logic [$clog2(MAX_HEIGHT+1)-1:0]     i_lim_h,
    input  logic                                i_full,
    output logic                                o_push,
    output ibd_pkg::t_px_cmd                    o_cmd,
    output logic [$clog2(MAX_WIDTH)-1:0]        o_addr
);

    localparam int unsigned FW = ibd_pkg::FACTOR_W;
    localparam int unsigned CW = $clog2(MAX_WIDTH);
    localparam int unsigned RW = $clog2(MAX_HEIGHT);
    localparam int unsigned W_W = $clog2(MAX_WIDTH + 1);
    localparam int unsigned H_W = $clog2(MAX_HEIGHT + 1);

    logic [CW-1:0] r_col;
    logic [CW-1:0] n_col;
    logic [RW-1:0] r_row;
    logic [RW-1:0] n_row;
    logic [FW-1:0] r_cib;
    logic [FW-1:0] n_cib;
    logic [FW-1:0] r_rib;
    logic [FW-1:0] n_rib;
    logic [CW-1:0] r_ocol;
    logic [CW-1:0] n_ocol;

    logic          accept;
    logic          in_region;
    logic [W_W-1:0] col_next;
    logic [H_W-1:0] row_next;
    logic          cib_end;
    logic          rib_end;
    logic          eol;
    logic [3:0]    gidx;

    assign o_stall = i_full || i_ctl.busy;
    assign accept  = i_valid && !o_stall;

    always_comb begin
        col_next  = W_W'(r_col) + W_W'(1);
        row_next  = H_W'(r_row) + H_W'(1);
        in_region = (W_W'(r_col) < i_lim_w) && (H_W'(r_row) < i_lim_h);
        cib_end   = (6'(r_cib) + 6'd1) >= 6'(i_ctl.factor);
        rib_end   = (6'(r_rib) + 6'd1) >= 6'(i_ctl.factor);
        eol       = (W_W'(r_ocol) + W_W'(1)) >= i_out_w;
        gidx      = 4'(ibd_pkg::mod3(r_rib)) * 4'd3 + 4'(ibd_pkg::mod3(r_cib));

        o_cmd.red    = i_red;
        o_cmd.green  = i_ctl.rgb ? i_green : 8'd0;
        o_cmd.blue   = i_ctl.rgb ? i_blue : 8'd0;
        o_cmd.weight = i_ctl.gauss ? ibd_pkg::GAUSS_W[gidx] : 3'd1;
        o_cmd.first  = (r_rib == '0) && (r_cib == '0);
        o_cmd.emit   = rib_end && cib_end;
        o_cmd.eol    = eol;
        o_cmd.eoi    = eol && (row_next >= i_lim_h);
        o_addr       = r_ocol;
        o_push       = accept && in_region;
    end

    always_comb begin
        n_col  = r_col;
        n_row  = r_row;
        n_cib  = r_cib;
        n_rib  = r_rib;
        n_ocol = r_ocol;
        if (accept) begin
            if (col_next >= i_w) begin
                n_col  = '0;
                n_cib  = '0;
                n_ocol = '0;
                if (row_next >= i_h) begin
                    n_row = '0;
                    n_rib = '0;
                end else begin
                    n_row = row_next[RW-1:0];
                    n_rib = rib_end ? '0 : r_rib + FW'(1);
                end
            end else begin
                n_col = col_next[CW-1:0];
                if (cib_end) begin
                    n_cib  = '0;
                    n_ocol = r_ocol + CW'(1);
                end else begin
                    n_cib = r_cib + FW'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_row  <= '0;
            r_cib  <= '0;
            r_rib  <= '0;
            r_ocol <= '0;
        end else begin
            r_col  <= n_col;
            r_row  <= n_row;
            r_cib  <= n_cib;
            r_rib  <= n_rib;
            r_ocol <= n_ocol;
        end
    end

    `IBD_ASSERT_SAME(a_cib_tracks_col, r_cib != '0, r_col != '0, "column in block set at row start")

endmodule

>>> hdl/ibd_fifo.sv
module ibd_fifo #(
    parameter int unsigned WIDTH = 44
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data
);

    localparam int unsigned AW = ibd_pkg::QAW;
    localparam int unsigned DEPTH = ibd_pkg::QDEPTH;

    logic [WIDTH-1:0] r_slot [DEPTH];
    logic [AW-1:0]    r_wp;
    logic [AW-1:0]    r_rp;
    logic [AW:0]      r_cnt;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_cnt == (AW+1)'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_slot[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= r_wp + AW'(1);
            end
            if (do_pop) begin
                r_rp <= r_rp + AW'(1);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + (AW+1)'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - (AW+1)'(1);
            end
        end
    end

endmodule

>>> hdl/ibd_back.sv
`include "image_block_downscaler_assert.svh"

module ibd_back #(
    parameter int unsigned MAX_WIDTH = 4096
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_head_valid,
    input  ibd_pkg::t_px_cmd              i_head_cmd,
    input  logic [$clog2(MAX_WIDTH)-1:0]  i_head_addr,
    output logic                          o_pop,
    input  logic [ibd_pkg::RECIP_W-1:0]   i_recip,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [7:0]                    o_out_red,
    output logic [7:0]                    o_out_green,
    output logic [7:0]                    o_out_blue,
    output logic                          o_end_of_row,
    output logic                          o_end_of_image
);

    localparam int unsigned CW = $clog2(MAX_WIDTH);
    localparam int unsigned SUM_W = ibd_pkg::SUM_W;
    localparam int unsigned EW = ibd_pkg::ENTRY_W;
    localparam int unsigned PW = ibd_pkg::PROD_W;
    localparam int unsigned K = ibd_pkg::RECIP_K;

    logic [EW-1:0] r_mem [MAX_WIDTH];

    logic             adv;
    logic             r_b_valid;
    ibd_pkg::t_px_cmd r_b_cmd;
    logic [CW-1:0]    r_b_addr;
    logic [EW-1:0]    r_rd;
    logic             r_last_vld;
    logic [CW-1:0]    r_last_addr;
    logic [EW-1:0]    r_last_sum;
    logic             r_c_valid;
    logic [EW-1:0]    r_c_sum;
    logic             r_c_eol;
    logic             r_c_eoi;
    logic             r_o_valid;

    logic [EW-1:0]    base;
    logic [EW-1:0]    sum_b;
    logic [23:0]      px;
    logic [10:0]      term [3];
    logic [PW-1:0]    prod [3];

    // The whole back end moves together unless a result sits stalled at the output.
    assign adv   = !r_o_valid || !i_stall;
    assign o_pop = adv && i_head_valid;

    always_comb begin
        if (r_b_cmd.first) begin
            base = '0;
        end else if (r_last_vld && (r_last_addr == r_b_addr)) begin
            base = r_last_sum;
        end else begin
            base = r_rd;
        end
        px = {r_b_cmd.blue, r_b_cmd.green, r_b_cmd.red};
        for (int c = 0; c < 3; c++) begin
            term[c] = 11'(px[c*8 +: 8]) * 11'(r_b_cmd.weight);
            sum_b[c*SUM_W +: SUM_W] = base[c*SUM_W +: SUM_W] + SUM_W'(term[c]);
        end
        for (int c = 0; c < 3; c++) begin
            prod[c] = PW'(r_c_sum[c*SUM_W +: SUM_W]) * PW'(i_recip);
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_rd <= r_mem[i_head_addr];
        end
        if (adv && r_b_valid) begin
            r_mem[r_b_addr] <= sum_b;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid  <= 1'b0;
            r_c_valid  <= 1'b0;
            r_o_valid  <= 1'b0;
            r_last_vld <= 1'b0;
        end else if (adv) begin
            r_b_valid <= i_head_valid;
            r_c_valid <= r_b_valid && r_b_cmd.emit;
            r_o_valid <= r_c_valid;
            if (r_b_valid) begin
                r_last_vld <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_b_cmd  <= i_head_cmd;
            r_b_addr <= i_head_addr;
            if (r_b_valid) begin
                r_last_addr <= r_b_addr;
                r_last_sum  <= sum_b;
            end
            r_c_sum        <= sum_b;
            r_c_eol        <= r_b_cmd.eol;
            r_c_eoi        <= r_b_cmd.eoi;
            o_out_red      <= prod[0][K +: 8];
            o_out_green    <= prod[1][K +: 8];
            o_out_blue     <= prod[2][K +: 8];
            o_end_of_row   <= r_c_eol;
            o_end_of_image <= r_c_eoi;
        end
    end

    assign o_valid = r_o_valid;

    `IBD_ASSERT_SAME(a_result_from_emit, $rose(r_c_valid), $past(r_b_valid && r_b_cmd.emit), "result without a completing pixel")
    `IBD_ASSERT_NEXT(a_frozen_pipe, !adv, $stable(r_b_valid) && $stable(r_c_valid), "pipeline moved while output stalled")

endmodule
